FILE: sv/epoch_seconds_to_date_top_defines.svh
// Assertion helpers for the file that checks this block.
`ifndef EPOCH_SECONDS_TO_DATE_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_DATE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/eps_pkg.sv
package eps_pkg;

    localparam int unsigned EPOCH_BITS = 32;
    localparam int unsigned DAY_BITS   = 5;
    localparam int unsigned HOUR_BITS  = 5;
    localparam int unsigned MIN_BITS   = 6;
    localparam int unsigned YEAR_BITS  = 12;
    localparam int unsigned OUT_BITS   = 40;

    localparam logic [EPOCH_BITS-1:0] DAY_SECONDS         = 32'd86400;
    localparam logic [EPOCH_BITS-1:0] HOUR_SECONDS        = 32'd3600;
    localparam logic [EPOCH_BITS-1:0] SECS_PER_MIN        = 32'd60;
    localparam logic [EPOCH_BITS-1:0] COMMON_YEAR_SECONDS = 32'd31536000;
    localparam logic [EPOCH_BITS-1:0] LEAP_YEAR_SECONDS   = 32'd31622400;

    localparam logic [YEAR_BITS-1:0] BASE_YEAR = 12'd1970;
    // Residues of 1970 modulo 4, 100 and 400.
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;

    localparam logic [3:0] MONTH_DEC = 4'd11;

    typedef struct packed {
        logic start;
        logic step;
    } t_year_ctl;

    // Length of a month in seconds: 28, 29, 30 or 31 days.
    function automatic logic [EPOCH_BITS-1:0] month_seconds(input logic [3:0] month,
                                                            input logic leap);
        logic [EPOCH_BITS-1:0] len;
        case (month)
            4'd1:    len = leap ? 32'd2505600 : 32'd2419200;
            4'd3, 4'd5, 4'd8, 4'd10: len = 32'd2592000;
            default: len = 32'd2678400;
        endcase
        return len;
    endfunction

endpackage

FILE: sv/eps_sub.sv
module eps_sub
    import eps_pkg::*;
(
    input  logic [EPOCH_BITS-1:0] i_a,
    input  logic [EPOCH_BITS-1:0] i_b,
    output logic                  o_ge,
    output logic [EPOCH_BITS-1:0] o_diff
);

    logic [EPOCH_BITS:0] w_full;

    // The borrow out of the subtraction doubles as the compare result.
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_full[EPOCH_BITS];
    assign o_diff = w_full[EPOCH_BITS-1:0];

endmodule

FILE: sv/eps_year.sv
module eps_year
    import eps_pkg::*;
(
    input  logic                 i_clk,
    input  t_year_ctl            i_ctl,
    output logic [YEAR_BITS-1:0] o_year,
    output logic                 o_leap
);

    logic [YEAR_BITS-1:0] r_year;
    logic [1:0]           r_mod4;
    logic [6:0]           r_mod100;
    logic [8:0]           r_mod400;

    // Residue counters track the 4/100/400 rule without any division.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_year   <= BASE_YEAR;
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
        end else if (i_ctl.step) begin
            r_year   <= r_year + 12'd1;
            r_mod4   <= r_mod4 + 2'd1;
            r_mod100 <= (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
        end
    end

    assign o_year = r_year;
    assign o_leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);

endmodule

FILE: sv/epoch_seconds_to_date_top.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// Gregorian date and time of day. One word goes in on the s_axis side and one
// word comes out on the m_axis side for it. All arithmetic runs through a
// single 32-bit compare-and-subtract unit under a small sequencer, so the
// block takes one word at a time: s_axis_tready is high only while the
// sequencer is idle. The sequencer takes whole years off the seconds count,
// then whole months, days, hours and minutes, one subtraction per cycle, and
// each walk ends with a compare that fails (the month walk also stops at
// December). The result then goes to the output register, and the block
// returns to idle before it takes the next word. The output register lets
// the block take the next word while the previous result still waits on
// m_axis_tready. There is no configuration.
`include "epoch_seconds_to_date_top_defines.svh"

module epoch_seconds_to_date_top
    import eps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] cal_year, [15:12] cal_month, [20:16] cal_day, [25:21] cal_hour,
    // [31:26] cal_minute, [37:32] cal_second, [39:38] zero
    output logic [39:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTHS,
        ST_DAYS,
        ST_HOURS,
        ST_MINS,
        ST_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [EPOCH_BITS-1:0] r_acc, n_acc;
    logic [3:0]            r_month, n_month;
    logic [DAY_BITS-1:0]   r_day, n_day;
    logic [HOUR_BITS-1:0]  r_hour, n_hour;
    logic [MIN_BITS-1:0]   r_minute, n_minute;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]   r_out_data, n_out_data;

    logic [EPOCH_BITS-1:0] w_b;
    logic [EPOCH_BITS-1:0] w_diff;
    logic                  w_ge;
    logic [YEAR_BITS-1:0]  w_year;
    logic                  w_leap;
    t_year_ctl             w_year_ctl;

    // The one arithmetic unit of the block.
    eps_sub u_sub (
        .i_a    (r_acc),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    eps_year u_year (
        .i_clk  (i_clk),
        .i_ctl  (w_year_ctl),
        .o_year (w_year),
        .o_leap (w_leap)
    );

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_b         = '0;
        w_year_ctl  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_acc            = s_axis_tdata;
                    w_year_ctl.start = 1'b1;
                    n_state          = ST_YEARS;
                end
            end
            ST_YEARS: begin
                // The year being consumed decides its own length.
                w_b = w_leap ? LEAP_YEAR_SECONDS : COMMON_YEAR_SECONDS;
                if (w_ge) begin
                    n_acc           = w_diff;
                    w_year_ctl.step = 1'b1;
                end else begin
                    n_month = 4'd0;
                    n_state = ST_MONTHS;
                end
            end
            ST_MONTHS: begin
                w_b = month_seconds(r_month, w_leap);
                if (w_ge && (r_month != MONTH_DEC)) begin
                    n_acc   = w_diff;
                    n_month = r_month + 4'd1;
                end else begin
                    n_day   = '0;
                    n_state = ST_DAYS;
                end
            end
            ST_DAYS: begin
                w_b = DAY_SECONDS;
                if (w_ge) begin
                    n_acc = w_diff;
                    n_day = r_day + 5'd1;
                end else begin
                    n_hour  = '0;
                    n_state = ST_HOURS;
                end
            end
            ST_HOURS: begin
                w_b = HOUR_SECONDS;
                if (w_ge) begin
                    n_acc  = w_diff;
                    n_hour = r_hour + 5'd1;
                end else begin
                    n_minute = '0;
                    n_state  = ST_MINS;
                end
            end
            ST_MINS: begin
                // What is left after the last minute is the second.
                w_b = SECS_PER_MIN;
                if (w_ge) begin
                    n_acc    = w_diff;
                    n_minute = r_minute + 6'd1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_data  = {2'b00, r_acc[MIN_BITS-1:0], r_minute, r_hour,
                                   5'(r_day + 5'd1), 4'(r_month + 4'd1), w_year};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_acc      <= n_acc;
        r_month    <= n_month;
        r_day      <= n_day;
        r_hour     <= n_hour;
        r_minute   <= n_minute;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A taken word always starts the year walk at 1970.
    `EPS_ASSERT_NEXT(a_start_years, s_axis_tvalid && s_axis_tready, (r_state == ST_YEARS) && (w_year == BASE_YEAR), "year walk did not start after accept")

    // The month walk never runs past December.
    `EPS_ASSERT_NOW(a_month_range, r_state == ST_MONTHS, r_month <= MONTH_DEC, "month index out of range")

    // The year walk stays inside the span that 32 bits of seconds can reach.
    `EPS_ASSERT_NOW(a_year_range, r_state == ST_YEARS || r_state == ST_MONTHS, w_year >= BASE_YEAR && w_year <= 12'd2106, "year out of range")

    // Every presented result has plausible time-of-day and month fields.
    `EPS_ASSERT_NOW(a_out_fields, m_axis_tvalid, m_axis_tdata[25:21] <= 5'd23 && m_axis_tdata[31:26] <= 6'd59 && m_axis_tdata[37:32] <= 6'd59 && m_axis_tdata[15:12] >= 4'd1 && m_axis_tdata[15:12] <= 4'd12, "result field out of range")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Calendar fields in the order they sit in m_axis_tdata, year in the low bits.
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } calendar_t;

    // One word waiting to be sent. When hold_for_drain is set, the sender
    // stays idle until every result already owed has come back.
    typedef struct {
        logic [31:0] secs;
        bit          hold_for_drain;
    } send_word_t;

    localparam int unsigned FIRST_YEAR    = 1970;
    localparam int unsigned SECS_IN_DAY   = 86400;
    localparam int unsigned SECS_IN_HOUR  = 3600;
    localparam int unsigned SECS_IN_MIN   = 60;
    localparam int unsigned RANDOM_WORDS  = 1350;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned MAX_REPORTS   = 10;

    localparam int unsigned COMMON_MONTH_DAYS [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] epoch_seconds
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [11:0] cal_year, [15:12] cal_month, [20:16] cal_day, [25:21] cal_hour,
    // [31:26] cal_minute, [37:32] cal_second, [39:38] zero
    logic [39:0] m_axis_tdata;

    send_word_t  send_queue [$];
    calendar_t   owed_dates [$];
    int unsigned error_count = 0;
    bit          word_taken = 1'b0;
    int          tx_gap = 0;
    int          tx_burst = 0;
    int          rx_stall = 0;
    int          rx_burst = 0;

    epoch_seconds_to_date_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock, starting low.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic bit is_leap_year(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic int unsigned days_in_year(input int unsigned year);
        return is_leap_year(year) ? 366 : 365;
    endfunction

    // Expected calendar date for a second count. Years are peeled off from
    // 1970 onward, then months from January, and the remainder gives the day.
    function automatic calendar_t predict_calendar(input logic [31:0] secs);
        int unsigned days;
        int unsigned rest;
        int unsigned year;
        int unsigned month;
        int unsigned month_days;
        calendar_t   date;
        days  = secs / SECS_IN_DAY;
        rest  = secs % SECS_IN_DAY;
        year  = FIRST_YEAR;
        month = 0;
        while (days >= days_in_year(year)) begin
            days -= days_in_year(year);
            year++;
        end
        forever begin
            month_days = COMMON_MONTH_DAYS[month];
            if (month == 1 && is_leap_year(year))
                month_days++;
            if (days < month_days || month >= 11)
                break;
            days -= month_days;
            month++;
        end
        date.year   = year[11:0];
        date.month  = 4'(month + 1);
        date.day    = 5'(days + 1);
        date.hour   = 5'(rest / SECS_IN_HOUR);
        date.minute = 6'((rest / SECS_IN_MIN) % 60);
        date.second = 6'(rest % SECS_IN_MIN);
        return date;
    endfunction

    // Idle length for either side: mostly none, sometimes a short one, rarely
    // a long one. A burst counter gives stretches with no idling at all.
    function automatic int pick_idle(inout int burst);
        int roll;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic void queue_word(input logic [31:0] secs, input bit hold);
        send_word_t w;
        w.secs           = secs;
        w.hold_for_drain = hold;
        send_queue.push_back(w);
    endfunction

    // Sender. It changes its outputs only at the falling edge. A word stays
    // on the bus until the monitor saw it taken at the last rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (tx_gap > 0) begin
                tx_gap        <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (send_queue.size() > 0 &&
                         (!send_queue[0].hold_for_drain || owed_dates.size() == 0)) begin
                s_axis_tdata  <= send_queue[0].secs;
                s_axis_tvalid <= 1'b1;
                tx_gap        <= pick_idle(tx_burst);
                void'(send_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, also changed only at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall      <= pick_idle(rx_burst);
        end
    end

    // Monitor. At the rising edge it sees the values from before the edge, so
    // both handshakes are judged on the same settled signals the block uses.
    // A taken input word adds its predicted date to the back of the queue; a
    // taken output word is checked against the front.
    always @(posedge i_clk) begin : monitor
        calendar_t want;
        calendar_t got;
        if (!i_rst_n) begin
            word_taken = 1'b0;
        end else begin
            word_taken = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[37:0];
                if (owed_dates.size() == 0) begin
                    note_error($sformatf("result word %h with nothing outstanding",
                                         m_axis_tdata));
                end else begin
                    want = owed_dates.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.hour !== want.hour ||
                        got.minute !== want.minute || got.second !== want.second ||
                        m_axis_tdata[39:38] !== 2'b00)
                        note_error($sformatf(
                            "expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d pad %b",
                            want.year, want.month, want.day,
                            want.hour, want.minute, want.second,
                            got.year, got.month, got.day,
                            got.hour, got.minute, got.second, m_axis_tdata[39:38]));
                end
            end
            if (word_taken)
                owed_dates.push_back(predict_calendar(s_axis_tdata));
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int unsigned roll;
        int unsigned year;
        int unsigned y;
        logic [31:0] secs;

        // Directed words: the ends of the range, the edges of a minute, hour
        // and day, the end of January in a common year, the end of February in a
        // common and a leap year, the turn of a leap year, the year 2000 which is a
        // leap year, the year 2100 which is not, and the top bit patterns.
        queue_word(32'd0, 1'b0);
        queue_word(32'd1, 1'b0);
        queue_word(32'd59, 1'b0);
        queue_word(32'd60, 1'b0);
        queue_word(32'd3599, 1'b0);
        queue_word(32'd3600, 1'b0);
        queue_word(32'd86399, 1'b0);
        queue_word(32'd86400, 1'b0);
        queue_word(32'd2678399, 1'b0);
        queue_word(32'd2678400, 1'b0);
        queue_word(32'd5097599, 1'b0);
        queue_word(32'd5097600, 1'b0);
        queue_word(32'd68169600, 1'b0);
        queue_word(32'd68255999, 1'b0);
        queue_word(32'd94694399, 1'b0);
        queue_word(32'd94694400, 1'b0);
        queue_word(32'd946684799, 1'b0);
        queue_word(32'd951782400, 1'b0);
        queue_word(32'd978307199, 1'b0);
        queue_word(32'd4107542399, 1'b0);
        queue_word(32'd4107542400, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0);
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'hFFFF_FFFE, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);

        // Random words. Full-range values make up half; the rest lean on day
        // and year boundaries and on both ends of the range. The first random
        // word and one in the middle wait for the pipe to empty.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                secs = $urandom;
            end else if (roll < 7) begin
                secs = 32'($urandom_range(0, 49710) * SECS_IN_DAY) +
                       32'($urandom_range(0, 4)) - 32'd2;
            end else if (roll == 7) begin
                year = $urandom_range(1971, 2106);
                secs = '0;
                for (y = FIRST_YEAR; y < year; y++)
                    secs += 32'(days_in_year(y) * SECS_IN_DAY);
                secs = secs + 32'($urandom_range(0, 2)) - 32'd1;
            end else if (roll == 8) begin
                secs = $urandom_range(0, 200000);
            end else begin
                secs = 32'hFFFF_FFFF - 32'($urandom_range(0, 5000000));
            end
            queue_word(secs, i == 0 || i == RANDOM_WORDS / 2);
        end

        // Synchronous reset held low, then released at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (send_queue.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (owed_dates.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (owed_dates.size() > 0)
            note_error($sformatf("%0d results never arrived", owed_dates.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("TIMEOUT @%0t", $realtime);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
